/* src/tdm_pkg.sv */
// Shared types, constants and opcodes of the table-driven DFA token matcher.
package tdm_pkg;

  localparam int unsigned NUM_STATES_DEF = 64;
  localparam int unsigned NUM_TOKENS_DEF = 15;

  localparam int unsigned OPER_W  = 2;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned STATE_W = 8;
  localparam int unsigned TOKEN_W = 4;
  localparam int unsigned START_W = 7;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [START_W-1:0] START_RESET  = 7'd1;
  localparam logic [STATE_W-1:0] REJECT_STATE = 8'hFF;

  typedef enum logic [OPER_W-1:0] {
    OP_WR_TRANS = 2'd0,
    OP_WR_TOKEN = 2'd1,
    OP_FEED     = 2'd2,
    OP_END      = 2'd3
  } op_e;

  typedef enum logic [PADDR_W-3:0] {
    REG_START_STATE = 1'b0
  } reg_e;

endpackage

/* src/tdm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tdm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tdm_cfg.sv */
// APB-style configuration register block holding the start state.
module tdm_cfg #(
  parameter int unsigned NUM_STATES = tdm_pkg::NUM_STATES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdm_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdm_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [tdm_pkg::START_W-1:0]  start_state_o
);

  logic [tdm_pkg::START_W-1:0] start_q, start_d;
  logic [tdm_pkg::START_W-1:0] wr_val;
  logic                        sel_start;
  logic                        wr_en;

  assign sel_start = (paddr[tdm_pkg::PADDR_W-1:2] == tdm_pkg::REG_START_STATE);
  assign wr_en     = psel && penable && pwrite && sel_start;
  assign pready    = 1'b1;

  always_comb begin
    wr_val = pwdata[tdm_pkg::START_W-1:0];
    if ({2'b00, wr_val} > 9'(NUM_STATES)) begin
      wr_val = tdm_pkg::START_W'(NUM_STATES);
    end
    start_d = wr_en ? wr_val : start_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= tdm_pkg::START_RESET;
    end else begin
      start_q <= start_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_start) begin
      prdata = tdm_pkg::PDATA_W'(start_q);
    end
  end

  assign start_state_o = start_q;

endmodule

/* src/table_driven_dfa_token_matcher.sv */
// Top level of the table-driven DFA token matcher: tables, state and result path.
//
// After reset the block clears the transition table one entry per cycle, and
// the token table alongside it; no item is accepted during that sweep, while
// configuration writes are taken. Afterwards one item is accepted every cycle,
// feeds back to back included, as long as the output is not stalled: the
// transition memory is addressed by the present state and the byte, and its
// registered read data is the next present state. A result passes from the
// lookup stage register into the output register, which holds it while
// out_stall_i is high. Table writes and start-state changes produce no
// result; a new start state takes effect at the next end of string.
module table_driven_dfa_token_matcher #(
  parameter int unsigned NUM_STATES = tdm_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_TOKENS = tdm_pkg::NUM_TOKENS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tdm_pkg::OPER_W-1:0]   operation_i,
  input  logic [tdm_pkg::INDEX_W-1:0]  state_index_i,
  input  logic [tdm_pkg::SYM_W-1:0]    symbol_i,
  input  logic signed [tdm_pkg::STATE_W-1:0] target_state_i,
  input  logic [tdm_pkg::TOKEN_W-1:0]  token_code_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [tdm_pkg::STATE_W-1:0] current_state_o,
  output logic                         rejected_o,
  output logic [tdm_pkg::TOKEN_W-1:0]  matched_token_o,
  output logic                         string_done_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdm_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdm_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned ROWS   = NUM_STATES + 1;
  localparam int unsigned SW     = $clog2(ROWS);
  localparam int unsigned TDEPTH = ROWS * 256;
  localparam int unsigned AW     = $clog2(TDEPTH);

  logic [tdm_pkg::START_W-1:0] start_state;

  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic [tdm_pkg::STATE_W-1:0] state_q, state_d;
  logic                        from_ram_q, from_ram_d;
  logic [tdm_pkg::STATE_W-1:0] pstate;
  logic                        pstate_ok;

  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_end_q, s1_end_d;
  logic                        s1_rej_q, s1_rej_d;
  logic [tdm_pkg::STATE_W-1:0] s1_state_q, s1_state_d;
  logic                        s1_adv;
  logic                        s1_state_ok;

  logic                        out_valid_q, out_valid_d;
  logic [tdm_pkg::STATE_W-1:0] out_state_q, out_state_d;
  logic                        out_rej_q, out_rej_d;
  logic [tdm_pkg::TOKEN_W-1:0] out_tok_q, out_tok_d;
  logic                        out_done_q, out_done_d;

  logic                        in_acc;
  tdm_pkg::op_e                op;
  logic                        idx_ok, tgt_ok, tok_ok;

  logic                        tr_we, tr_re;
  logic [AW-1:0]               tr_waddr, tr_raddr;
  logic [tdm_pkg::STATE_W-1:0] tr_wdata, tr_rdata;
  logic                        tk_we, tk_re;
  logic [SW-1:0]               tk_waddr, tk_raddr;
  logic [tdm_pkg::TOKEN_W-1:0] tk_wdata, tk_rdata;

  tdm_cfg #(
    .NUM_STATES (NUM_STATES)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start_state_o (start_state)
  );

  assign op     = tdm_pkg::op_e'(operation_i);
  assign s1_adv = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_adv);
  assign in_acc = in_valid_i && !in_stall_o;

  assign idx_ok = {2'b00, state_index_i} <= 9'(NUM_STATES);
  assign tgt_ok = ($signed({target_state_i[7], target_state_i}) >= -9'sd1) &&
                  ($signed({target_state_i[7], target_state_i}) <= $signed(9'(NUM_STATES)));
  assign tok_ok = {5'b00000, token_code_i} <= 9'(NUM_TOKENS);

  assign pstate      = from_ram_q ? tr_rdata : state_q;
  assign pstate_ok   = !pstate[7] && ({1'b0, pstate} <= 9'(NUM_STATES));
  assign s1_state_ok = !s1_state_q[7] && ({1'b0, s1_state_q} <= 9'(NUM_STATES));

  // clearing sweep after reset
  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(TDEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // memory ports
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = {SW'(state_index_i), symbol_i};
    tr_wdata = target_state_i;
    tk_we    = 1'b0;
    tk_waddr = SW'(state_index_i);
    tk_wdata = token_code_i;
    if (clr_active_q) begin
      tr_we    = 1'b1;
      tr_waddr = clr_cnt_q;
      tr_wdata = '0;
      tk_we    = clr_cnt_q < AW'(ROWS);
      tk_waddr = SW'(clr_cnt_q);
      tk_wdata = '0;
    end else if (in_acc) begin
      tr_we = (op == tdm_pkg::OP_WR_TRANS) && idx_ok && tgt_ok;
      tk_we = (op == tdm_pkg::OP_WR_TOKEN) && idx_ok && tok_ok;
    end
  end

  assign tr_re    = in_acc && (op == tdm_pkg::OP_FEED) && pstate_ok;
  assign tr_raddr = {SW'(pstate), symbol_i};
  assign tk_re    = in_acc && (op == tdm_pkg::OP_END) && pstate_ok;
  assign tk_raddr = SW'(pstate);

  tdm_ram #(
    .WIDTH (tdm_pkg::STATE_W),
    .DEPTH (TDEPTH)
  ) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .re_i    (tr_re),
    .raddr_i (tr_raddr),
    .rdata_o (tr_rdata)
  );

  tdm_ram #(
    .WIDTH (tdm_pkg::TOKEN_W),
    .DEPTH (ROWS)
  ) u_token_ram (
    .clk_i   (clk_i),
    .we_i    (tk_we),
    .waddr_i (tk_waddr),
    .wdata_i (tk_wdata),
    .re_i    (tk_re),
    .raddr_i (tk_raddr),
    .rdata_o (tk_rdata)
  );

  // present state and lookup stage
  always_comb begin
    state_d    = state_q;
    from_ram_d = from_ram_q;
    s1_valid_d = s1_valid_q && !s1_adv;
    s1_end_d   = s1_end_q;
    s1_rej_d   = s1_rej_q;
    s1_state_d = s1_state_q;
    if (in_acc) begin
      unique case (op)
        tdm_pkg::OP_WR_TRANS, tdm_pkg::OP_WR_TOKEN: begin
          state_d    = pstate;
          from_ram_d = 1'b0;
        end
        tdm_pkg::OP_FEED: begin
          state_d    = tdm_pkg::REJECT_STATE;
          from_ram_d = pstate_ok;
          s1_valid_d = 1'b1;
          s1_end_d   = 1'b0;
          s1_rej_d   = !pstate_ok;
          s1_state_d = pstate;
        end
        tdm_pkg::OP_END: begin
          state_d    = {1'b0, start_state};
          from_ram_d = 1'b0;
          s1_valid_d = 1'b1;
          s1_end_d   = 1'b1;
          s1_rej_d   = 1'b0;
          s1_state_d = pstate;
        end
        default: begin
          state_d = pstate;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_state_d = out_state_q;
    out_rej_d   = out_rej_q;
    out_tok_d   = out_tok_q;
    out_done_d  = out_done_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
      if (s1_end_q) begin
        out_state_d = s1_state_q;
        out_tok_d   = s1_state_ok ? tk_rdata : '0;
        out_done_d  = 1'b1;
      end else begin
        out_state_d = s1_rej_q ? tdm_pkg::REJECT_STATE : tr_rdata;
        out_tok_d   = '0;
        out_done_d  = 1'b0;
      end
      out_rej_d = (out_state_d == tdm_pkg::REJECT_STATE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      state_q      <= {1'b0, tdm_pkg::START_RESET};
      from_ram_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      state_q      <= state_d;
      from_ram_q   <= from_ram_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_end_q    <= s1_end_d;
    s1_rej_q    <= s1_rej_d;
    s1_state_q  <= s1_state_d;
    out_state_q <= out_state_d;
    out_rej_q   <= out_rej_d;
    out_tok_q   <= out_tok_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign current_state_o = out_state_q;
  assign rejected_o      = out_rej_q;
  assign matched_token_o = out_tok_q;
  assign string_done_o   = out_done_q;

`ifndef ASSERT_OFF
  a_rej_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |->
      (matched_token_o == '0) && (current_state_o == tdm_pkg::REJECT_STATE))
    else $error("rejected result carries a token or a live state");

  a_feed_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !string_done_o |-> matched_token_o == '0)
    else $error("feed result carries a token");

  a_ram_state_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    from_ram_q |-> !clr_active_q)
    else $error("state taken from memory during clearing sweep");

  a_held_lookup_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv && !s1_end_q && !s1_rej_q |=> $stable(tr_rdata))
    else $error("lookup data changed while result was held");

  a_held_token_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv && s1_end_q && s1_state_ok |=> $stable(tk_rdata))
    else $error("token data changed while result was held");
`endif

endmodule
